[rtl/nvqh_pkg.sv]
// shared types and constants for the nvme i/o queue host engine
`timescale 1ns / 1ps
`default_nettype none
package nvqh_pkg;

   // request command codes
   localparam logic [1:0] CMD_READ       = 2'd0;
   localparam logic [1:0] CMD_WRITE      = 2'd1;
   localparam logic [1:0] CMD_COMPLETION = 2'd2;

   // result outcome codes
   localparam logic [1:0] OUTCOME_SUBMITTED = 2'd0;
   localparam logic [1:0] OUTCOME_SUCCESS   = 2'd1;
   localparam logic [1:0] OUTCOME_ERROR     = 2'd2;
   localparam logic [1:0] OUTCOME_PENDING   = 2'd3;

   // submission opcodes
   localparam logic [7:0] OPC_READ  = 8'h02;
   localparam logic [7:0] OPC_WRITE = 8'h01;

   // register indexes
   localparam logic REG_DOORBELL_STRIDE = 1'b0;

   // doorbell layout and field widths
   localparam logic [18:0] DOORBELL_BASE = 19'h01000;
   localparam int          PAGE_SHIFT    = 12;
   localparam int          SECTOR_SHIFT  = 9;
   localparam int          DB_VALUE_W    = 12;
   localparam int          STATUS_W      = 15;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [63:0] lba;
      logic [16:0] sector_count;
      logic [63:0] buffer_address;
      logic [15:0] completion_status;
   } req_type;

   typedef struct packed {
      logic [1:0]  outcome;
      logic [7:0]  entry_opcode;
      logic [15:0] entry_command_id;
      logic [63:0] entry_prp_first;
      logic [63:0] entry_prp_second;
      logic [63:0] entry_lba;
      logic [15:0] entry_count_less_one;
      logic [18:0] doorbell_offset;
      logic [11:0] doorbell_value;
      logic [14:0] status_code;
   } rsp_type;

endpackage
`default_nettype wire

[rtl/nvqh_csr.sv]
// apb register block holding the doorbell stride
`timescale 1ns / 1ps
`default_nettype none
module nvqh_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready,
   output logic      [3:0]  doorbell_stride
);

   logic [3:0] stride_ff;
   logic [3:0] stride_in;
   logic       write_hit;

   assign pready = 1'b1;
   assign write_hit = psel & penable & pwrite;

   // register write decode
   always_comb begin
      stride_in = stride_ff;
      if (write_hit) begin
         unique case (paddr[2])
            nvqh_pkg::REG_DOORBELL_STRIDE: stride_in = pwdata[3:0];
            default: stride_in = stride_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff <= 4'd0;
      end else begin
         stride_ff <= stride_in;
      end
   end

   // register read decode
   always_comb begin
      unique case (paddr[2])
         nvqh_pkg::REG_DOORBELL_STRIDE: prdata = {28'd0, stride_ff};
         default: prdata = 32'd0;
      endcase
   end

   assign doorbell_stride = stride_ff;

endmodule
`default_nettype wire

[rtl/nvqh_engine.sv]
// queue pointers, phase and command id, and the per-transaction result logic
`timescale 1ns / 1ps
`default_nettype none
module nvqh_engine #(
   parameter int QUEUE_DEPTH = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [3:0]        doorbell_stride,
   input  wire logic              advance,
   input  wire nvqh_pkg::req_type item,
   output nvqh_pkg::rsp_type      result
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   logic [PTR_W-1:0] tail_ff;
   logic [PTR_W-1:0] tail_in;
   logic [PTR_W-1:0] head_ff;
   logic [PTR_W-1:0] head_in;
   logic             phase_ff;
   logic             phase_in;
   logic [15:0]      cmd_id_ff;
   logic [15:0]      cmd_id_in;

   logic [PTR_W-1:0] tail_next;
   logic [PTR_W-1:0] head_next;
   logic [18:0]      spacing;
   logic [18:0]      sq_bell;
   logic [18:0]      cq_bell;
   logic [63:0]      span_end;
   logic             page_cross;
   logic [63:0]      prp_second;
   logic [14:0]      code;

   // ring pointer increment with wrap at the queue depth
   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] v);
      logic [PTR_W:0] sum;
      sum = {1'b0, v} + {{PTR_W{1'b0}}, 1'b1};
      if (sum >= (PTR_W + 1)'(QUEUE_DEPTH)) begin
         return '0;
      end
      return sum[PTR_W-1:0];
   endfunction

   assign tail_next = ring_next(tail_ff);
   assign head_next = ring_next(head_ff);

   // doorbell offsets for queue 1 tail and head
   assign spacing = 19'd4 << doorbell_stride;
   assign sq_bell = nvqh_pkg::DOORBELL_BASE + (spacing << 1);
   assign cq_bell = nvqh_pkg::DOORBELL_BASE + (spacing << 1) + spacing;

   // page crossing test on the exclusive end address
   assign span_end   = item.buffer_address + {38'd0, item.sector_count, 9'd0};
   assign page_cross = span_end[63:nvqh_pkg::PAGE_SHIFT]
                       != item.buffer_address[63:nvqh_pkg::PAGE_SHIFT];
   assign prp_second = page_cross ?
                       {item.buffer_address[63:nvqh_pkg::PAGE_SHIFT] + 52'd1, 12'd0} :
                       64'd0;
   assign code = item.completion_status[15:1];

   // result and next state
   always_comb begin
      result    = '0;
      tail_in   = tail_ff;
      head_in   = head_ff;
      phase_in  = phase_ff;
      cmd_id_in = cmd_id_ff;
      result.outcome = nvqh_pkg::OUTCOME_PENDING;
      case (item.cmd) inside
         nvqh_pkg::CMD_READ, nvqh_pkg::CMD_WRITE: begin
            result.outcome      = nvqh_pkg::OUTCOME_SUBMITTED;
            result.entry_opcode = (item.cmd == nvqh_pkg::CMD_READ) ?
                                  nvqh_pkg::OPC_READ : nvqh_pkg::OPC_WRITE;
            result.entry_command_id     = cmd_id_ff;
            result.entry_prp_first      = item.buffer_address;
            result.entry_prp_second     = prp_second;
            result.entry_lba            = item.lba;
            result.entry_count_less_one = item.sector_count[15:0] - 16'd1;
            result.doorbell_offset      = sq_bell;
            result.doorbell_value       = nvqh_pkg::DB_VALUE_W'(tail_next);
            cmd_id_in = cmd_id_ff + 16'd1;
            tail_in   = tail_next;
         end
         nvqh_pkg::CMD_COMPLETION: begin
            if (item.completion_status[0] == phase_ff) begin
               result.outcome = (code == '0) ? nvqh_pkg::OUTCOME_SUCCESS :
                                               nvqh_pkg::OUTCOME_ERROR;
               result.doorbell_offset = cq_bell;
               result.doorbell_value  = nvqh_pkg::DB_VALUE_W'(head_next);
               result.status_code     = code;
               head_in = head_next;
               if (head_next == '0) begin
                  phase_in = ~phase_ff;
               end
            end
         end
         default: begin
            result.outcome = nvqh_pkg::OUTCOME_PENDING;
         end
      endcase
   end

   // state update when a transaction moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff   <= '0;
         head_ff   <= '0;
         phase_ff  <= 1'b1;
         cmd_id_ff <= 16'd0;
      end else if (advance) begin
         tail_ff   <= tail_in;
         head_ff   <= head_in;
         phase_ff  <= phase_in;
         cmd_id_ff <= cmd_id_in;
      end
   end

endmodule
`default_nettype wire

[rtl/nvme_io_queue_host_engine_top.sv]
// top level of the nvme i/o queue host engine
`timescale 1ns / 1ps
`default_nettype none
// Host side of NVMe I/O queue pair 1. A read or write request becomes one
// submission entry (opcode, rolling command id, PRP1, PRP2 when the transfer
// end address falls in a different 4 KiB page, LBA, zero-based count) plus the
// submission tail doorbell offset and new tail. A completion request carries
// the status half-word at the head; on a phase match the head advances, the
// phase flips on wrap, and the head doorbell and status come back, otherwise
// the result reads pending. One transaction per cycle is sustained while
// rsp_ready drains the result register: each passes an input register,
// one level of pointer, compare and add logic, and a result register that
// drives the result port. The doorbell stride register sits at APB address
// 0; it must be written by the user only while idle, which the block does not enforce.
module nvme_io_queue_host_engine_top #(
   parameter int QUEUE_DEPTH = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire nvqh_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output nvqh_pkg::rsp_type      rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready
);

   logic              in_valid_ff;
   logic              in_valid_in;
   nvqh_pkg::req_type in_data_ff;
   logic              out_valid_ff;
   logic              out_valid_in;
   nvqh_pkg::rsp_type out_data_ff;
   nvqh_pkg::rsp_type result;
   logic [3:0]        doorbell_stride;
   logic              out_move;
   logic              advance;
   logic              req_fire;

   nvqh_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .doorbell_stride (doorbell_stride)
   );

   nvqh_engine #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .doorbell_stride (doorbell_stride),
      .advance         (advance),
      .item            (in_data_ff),
      .result          (result)
   );

   // pipeline flow control
   assign out_move  = ~out_valid_ff | rsp_ready;
   assign advance   = in_valid_ff & out_move;
   assign req_ready = ~in_valid_ff | out_move;
   assign req_fire  = req_valid & req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // a submitted entry always carries a read or write opcode and no status
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.outcome == nvqh_pkg::OUTCOME_SUBMITTED) |->
      ((rsp_data.entry_opcode == nvqh_pkg::OPC_READ ||
        rsp_data.entry_opcode == nvqh_pkg::OPC_WRITE) && rsp_data.status_code == '0))
      else $error("submitted entry with bad opcode or nonzero status");

   // a pending result rings no doorbell
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.outcome == nvqh_pkg::OUTCOME_PENDING) |->
      (rsp_data.doorbell_offset == '0 && rsp_data.doorbell_value == '0))
      else $error("pending result carries a doorbell");

   // a held input transaction is not dropped while the result side stalls
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_move) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("input stage lost a stalled transaction");

   // the input side is open whenever the input register is empty
   assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input stage empty but not ready");

endmodule
`default_nettype wire
